// ===== hdl/krt_pkg.sv =====
// shared types, codes and sizes for the keyed record table
`timescale 1ns / 1ps

package krt_pkg;

  // default number of record cells
  localparam int KRT_DEPTH = 64;

  // field widths
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;

  // command codes
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_LIST   = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_DUP      = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  // what a cell does at the next edge
  typedef enum logic [2:0] {
    OP_HOLD     = 3'd0,
    OP_LOAD     = 3'd1,
    OP_SET_VAL  = 3'd2,
    OP_TAKE_NB  = 3'd3,
    OP_TAKE_HD  = 3'd4
  } cell_op_t;

  // per-cell control from the sequencer
  typedef struct packed {
    cell_op_t op;
    logic     occ;
  } cell_ctrl_t;

endpackage

// ===== hdl/krt_cell.sv =====
// one record cell: key and value storage with a local key compare
`timescale 1ns / 1ps

module krt_cell
  import krt_pkg::*;
(
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [KEY_W-1:0] search_key,
  input  logic [KEY_W-1:0] bus_key,
  input  logic [VAL_W-1:0] bus_val,
  input  logic [KEY_W-1:0] nb_key,
  input  logic [VAL_W-1:0] nb_val,
  input  logic [KEY_W-1:0] hd_key,
  input  logic [VAL_W-1:0] hd_val,
  output logic [KEY_W-1:0] key,
  output logic [VAL_W-1:0] val,
  output logic             match
);

  // only an occupied cell may report a hit
  assign match = ctrl.occ && (key == search_key);

  // record storage
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LOAD: begin
        key <= bus_key;
        val <= bus_val;
      end
      OP_SET_VAL: begin
        val <= bus_val;
      end
      OP_TAKE_NB: begin
        key <= nb_key;
        val <= nb_val;
      end
      OP_TAKE_HD: begin
        key <= hd_key;
        val <= hd_val;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/keyed_record_table_core.sv =====
// keyed record table: row of record cells and the command sequencer
// insert, update, delete: executed once the output is free; one command at a time
// list: one record per cycle while the output is free, out of cell 0 as the row rotates
// the key search is a parallel compare in every cell; delete shifts the row down
// reset clears the record count and the handshake; cell contents stay undefined until written
`timescale 1ns / 1ps

module keyed_record_table_core
  import krt_pkg::*;
#(
  parameter int DEPTH = KRT_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  // slave side
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [KEY_W+VAL_W-1:0] s_tdata,   // record_key, record_value
  input  logic [1:0]             s_tuser,   // cmd
  // master side
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [KEY_W+VAL_W-1:0] m_tdata,   // out_key, out_value
  output logic [2:0]             m_tuser,   // status
  output logic                   m_tlast
);

  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVLS = $clog2(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LIST
  } state_t;

  state_t            state;
  logic [CNTW-1:0]   count;
  logic [CNTW-1:0]   count_next;
  logic [IDXW-1:0]   list_idx;
  cmd_t              req_cmd;
  logic [KEY_W-1:0]  req_key;
  logic [VAL_W-1:0]  req_val;

  logic [KEY_W-1:0]  cell_key [DEPTH];
  logic [VAL_W-1:0]  cell_val [DEPTH];
  logic [DEPTH-1:0]  match;
  logic [DEPTH-1:0]  pre [LVLS+1];
  logic [DEPTH-1:0]  at_or_after;
  cell_ctrl_t        ctrl [DEPTH];

  logic              any_match;
  logic [VAL_W-1:0]  hit_val;
  logic              out_free;
  logic              out_load;
  logic              list_last;

  status_t           ex_status;
  logic [KEY_W-1:0]  ex_key;
  logic [VAL_W-1:0]  ex_val;
  logic              ex_emit;

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE);
  assign any_match = |match;
  assign list_last = ((CNTW'(list_idx) + CNTW'(1)) == count);

  // a new result enters the output register this cycle
  assign out_load  = out_free && ((state == S_EXEC && ex_emit) || state == S_LIST);

  // row of cells, each taking its upper neighbour on a shift
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] nbk;
    logic [VAL_W-1:0] nbv;
    if (i == DEPTH - 1) begin : g_tail
      assign nbk = cell_key[i];
      assign nbv = cell_val[i];
    end else begin : g_mid
      assign nbk = cell_key[i+1];
      assign nbv = cell_val[i+1];
    end
    krt_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl[i]),
      .search_key (req_key),
      .bus_key    (req_key),
      .bus_val    (req_val),
      .nb_key     (nbk),
      .nb_val     (nbv),
      .hd_key     (cell_key[0]),
      .hd_val     (cell_val[0]),
      .key        (cell_key[i]),
      .val        (cell_val[i]),
      .match      (match[i])
    );
  end

  // prefix or of the hit vector: cells at or above the hit shift on delete
  always_comb begin
    pre[0] = match;
    for (int l = 0; l < LVLS; l++) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (i >= (1 << l)) begin
          pre[l+1][i] = pre[l][i] | pre[l][i - (1 << l)];
        end else begin
          pre[l+1][i] = pre[l][i];
        end
      end
    end
    at_or_after = pre[LVLS];
  end

  // value of the hit record
  always_comb begin
    hit_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_val = hit_val | ({VAL_W{match[i]}} & cell_val[i]);
    end
  end

  // command outcome in the execute cycle
  always_comb begin
    ex_status  = ST_OK;
    ex_key     = '0;
    ex_val     = '0;
    ex_emit    = 1'b1;
    count_next = count;
    unique case (req_cmd)
      CMD_INSERT: begin
        if (count == CNTW'(DEPTH)) begin
          ex_status = ST_FULL;
        end else if (any_match) begin
          ex_status = ST_DUP;
        end else begin
          ex_key     = req_key;
          ex_val     = req_val;
          count_next = count + CNTW'(1);
        end
      end
      CMD_UPDATE: begin
        if (any_match) begin
          ex_key = req_key;
          ex_val = req_val;
        end else begin
          ex_status = ST_NOTFOUND;
        end
      end
      CMD_DELETE: begin
        if (any_match) begin
          ex_key     = req_key;
          ex_val     = hit_val;
          count_next = count - CNTW'(1);
        end else begin
          ex_status = ST_NOTFOUND;
        end
      end
      CMD_LIST: begin
        if (count == '0) begin
          ex_status = ST_EMPTY;
        end else begin
          ex_emit = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // per-cell operation select
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctrl[i].occ = (CNTW'(i) < count);
      ctrl[i].op  = OP_HOLD;
      if (state == S_EXEC && out_free) begin
        unique case (req_cmd)
          CMD_INSERT: begin
            if (ex_status == ST_OK && CNTW'(i) == count) begin
              ctrl[i].op = OP_LOAD;
            end
          end
          CMD_UPDATE: begin
            if (match[i]) begin
              ctrl[i].op = OP_SET_VAL;
            end
          end
          CMD_DELETE: begin
            if (at_or_after[i]) begin
              ctrl[i].op = OP_TAKE_NB;
            end
          end
          default: begin
          end
        endcase
      end else if (state == S_LIST && out_free) begin
        if (CNTW'(i) + CNTW'(1) == count) begin
          ctrl[i].op = OP_TAKE_HD;
        end else if (CNTW'(i) < count) begin
          ctrl[i].op = OP_TAKE_NB;
        end
      end
    end
  end

  // sequencer, record count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      list_idx <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req_cmd <= cmd_t'(s_tuser);
            req_key <= s_tdata[KEY_W-1:0];
            req_val <= s_tdata[KEY_W+VAL_W-1:KEY_W];
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            count <= count_next;
            if (ex_emit) begin
              m_tuser  <= ex_status;
              m_tdata  <= {ex_val, ex_key};
              m_tlast  <= 1'b1;
              state    <= S_IDLE;
            end else begin
              list_idx <= '0;
              state    <= S_LIST;
            end
          end
        end
        S_LIST: begin
          if (out_free) begin
            m_tuser  <= ST_OK;
            m_tdata  <= {cell_val[0], cell_key[0]};
            m_tlast  <= list_last;
            if (list_last) begin
              list_idx <= '0;
              state    <= S_IDLE;
            end else begin
              list_idx <= list_idx + IDXW'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // record count stays within the row
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(DEPTH))
    else $error("record count beyond depth");

  // stored keys stay distinct, so at most one cell hits
  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("more than one cell matched the key");

  // only the closing result of a command can carry an error status
  a_status_mid_list: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser == ST_OK)
    else $error("error status on a non-final result");

  // the record count only moves in the execute cycle, by one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    state != S_EXEC |=> $stable(count) || $past(rst))
    else $error("record count changed outside execute");

endmodule
